### rtl/wfsm_pkg.sv
// Package for the wall-facing sensor mask unit.
// Holds widths, sensor bit positions, wall and register codes, and reset values.
// No dependencies.
package wfsm_pkg;

  localparam int COORD_WIDTH = 13;
  localparam int HEAD_WIDTH = 9;
  localparam int MASK_WIDTH = 6;
  localparam int CONE_WIDTH = 6;
  localparam int ANG_WIDTH = 11;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = COORD_WIDTH;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [HEAD_WIDTH-1:0] head_t;
  typedef logic signed [ANG_WIDTH-1:0] angle_t;
  typedef logic [MASK_WIDTH-1:0] mask_t;
  typedef logic [CONE_WIDTH-1:0] cone_t;

  // Sensor bits: front left, center, right, then back left, center, right.
  localparam mask_t BIT_FL = 6'h01;
  localparam mask_t BIT_FC = 6'h02;
  localparam mask_t BIT_FR = 6'h04;
  localparam mask_t BIT_BL = 6'h08;
  localparam mask_t BIT_BC = 6'h10;
  localparam mask_t BIT_BR = 6'h20;
  localparam mask_t ALL_BITS = 6'h3f;

  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam cone_t CONE_RESET = 6'd22;

  // Angle constants in degrees.
  localparam angle_t ANG_90 = 11'sd90;
  localparam angle_t ANG_180 = 11'sd180;
  localparam angle_t ANG_360 = 11'sd360;

  typedef enum logic [1:0] {
    WALL_WEST  = 2'd0,
    WALL_EAST  = 2'd1,
    WALL_NORTH = 2'd2,
    WALL_SOUTH = 2'd3
  } wall_t;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_X_LOW  = 3'd0,
    REG_X_HIGH = 3'd1,
    REG_Y_LOW  = 3'd2,
    REG_Y_HIGH = 3'd3,
    REG_CONE   = 3'd4,
    REG_STATIC = 3'd5
  } cfg_reg_t;

  // Angle that is added to the heading when facing the given wall.
  function automatic angle_t wall_offset(wall_t wall);
    angle_t ofs;
    unique case (wall)
      WALL_WEST:  ofs = '0;
      WALL_EAST:  ofs = -ANG_180;
      WALL_NORTH: ofs = -ANG_90;
      WALL_SOUTH: ofs = ANG_90;
      default:    ofs = '0;
    endcase
    return ofs;
  endfunction

endpackage

### rtl/wfsm_wall_clear.sv
// Sector decode for one wall: offsets the heading, wraps it once and picks
// the sensor bits to clear. Depends on wfsm_pkg.
module wfsm_wall_clear (
  input  wfsm_pkg::head_t heading,
  input  wfsm_pkg::wall_t wall,
  input  wfsm_pkg::cone_t cone,
  output wfsm_pkg::mask_t clear
);
  import wfsm_pkg::*;

  angle_t sum;
  angle_t a;
  angle_t c;

  // Offset and single wrap into the half-open circle.
  always_comb begin
    sum = angle_t'(heading) + wall_offset(wall);
    c = angle_t'({1'b0, cone});
    if (sum < -ANG_180) begin
      a = sum + ANG_360;
    end else if (sum >= ANG_180) begin
      a = sum - ANG_360;
    end else begin
      a = sum;
    end
  end

  // First matching sector wins.
  always_comb begin
    priority if (a >= ANG_90 - c && a < ANG_90 + c) begin
      clear = BIT_FR | BIT_BR;
    end else if (a >= ANG_90 + c && a < ANG_180 - c) begin
      clear = BIT_FC | BIT_FR;
    end else if (a >= ANG_180 - c || a < -ANG_180 + c) begin
      clear = BIT_FL | BIT_FC | BIT_FR;
    end else if (a < -ANG_90 - c) begin
      clear = BIT_FL | BIT_FC;
    end else if (a < -ANG_90 + c) begin
      clear = BIT_FL | BIT_BL;
    end else if (a < -c) begin
      clear = BIT_BL | BIT_BC;
    end else if (a >= -c && a < c) begin
      clear = BIT_BL | BIT_BC | BIT_BR;
    end else begin
      clear = BIT_BC | BIT_BR;
    end
  end

endmodule

### rtl/wall_facing_sensor_mask_unit.sv
// Top level of the wall-facing sensor mask unit: input register, wall decode,
// output register and configuration registers. Depends on wfsm_pkg, wfsm_wall_clear.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   pos_x, pos_y, heading, raw_detect
//   out      out_valid / out_ready effective_detect, dynamic_mask, detection_valid
//   cfg      cfg_we                cfg_index, cfg_data
//
// One word per cycle unless the output stalls; a word in the input register
// moves to the result register when that register loads, and leaves from there.
// The input register and the result register sit around the decode.
// A stall on the output holds the result register; the input register keeps
// taking words until it also holds one.
// Synchronous reset empties both stages and restores the register defaults.
module wall_facing_sensor_mask_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  wfsm_pkg::coord_t                      pos_x,
  input  wfsm_pkg::coord_t                      pos_y,
  input  wfsm_pkg::head_t                       heading,
  input  wfsm_pkg::mask_t                       raw_detect,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output wfsm_pkg::mask_t                       effective_detect,
  output wfsm_pkg::mask_t                       dynamic_mask,
  output logic                                  detection_valid,
  input  logic                                  cfg_we,
  input  logic [wfsm_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  logic [wfsm_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
  import wfsm_pkg::*;

  coord_t x_low_limit;
  coord_t x_high_limit;
  coord_t y_low_limit;
  coord_t y_high_limit;
  cone_t  cone_half_width;
  mask_t  static_mask;

  logic   s1_valid;
  coord_t s1_x;
  coord_t s1_y;
  head_t  s1_head;
  mask_t  s1_raw;

  logic   s2_load;
  logic   s1_load;
  logic   west_on;
  logic   east_on;
  logic   north_on;
  logic   south_on;
  mask_t  west_clr;
  mask_t  east_clr;
  mask_t  north_clr;
  mask_t  south_clr;
  mask_t  dyn_next;
  mask_t  eff_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_low_limit <= COORD_MIN;
      x_high_limit <= COORD_MAX;
      y_low_limit <= COORD_MIN;
      y_high_limit <= COORD_MAX;
      cone_half_width <= CONE_RESET;
      static_mask <= ALL_BITS;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_X_LOW:  x_low_limit <= coord_t'(cfg_data);
        REG_X_HIGH: x_high_limit <= coord_t'(cfg_data);
        REG_Y_LOW:  y_low_limit <= coord_t'(cfg_data);
        REG_Y_HIGH: y_high_limit <= coord_t'(cfg_data);
        REG_CONE:   cone_half_width <= cfg_data[CONE_WIDTH-1:0];
        REG_STATIC: static_mask <= cfg_data[MASK_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Stage handshake: each stage loads when empty or when it drains this cycle.
  assign s2_load = s1_valid && (!out_valid || out_ready);
  assign s1_load = in_valid && in_ready;
  assign in_ready = !s1_valid || s2_load;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_x <= pos_x;
      s1_y <= pos_y;
      s1_head <= heading;
      s1_raw <= raw_detect;
    end
  end

  // Wall activity from the position limits.
  assign west_on = s1_x < x_low_limit;
  assign east_on = s1_x > x_high_limit;
  assign north_on = s1_y < y_low_limit;
  assign south_on = s1_y > y_high_limit;

  wfsm_wall_clear u_west (
    .heading(s1_head), .wall(WALL_WEST), .cone(cone_half_width), .clear(west_clr)
  );
  wfsm_wall_clear u_east (
    .heading(s1_head), .wall(WALL_EAST), .cone(cone_half_width), .clear(east_clr)
  );
  wfsm_wall_clear u_north (
    .heading(s1_head), .wall(WALL_NORTH), .cone(cone_half_width), .clear(north_clr)
  );
  wfsm_wall_clear u_south (
    .heading(s1_head), .wall(WALL_SOUTH), .cone(cone_half_width), .clear(south_clr)
  );

  // Combine the clears of the active walls and apply both masks.
  always_comb begin
    dyn_next = ALL_BITS;
    if (west_on) dyn_next = dyn_next & ~west_clr;
    if (east_on) dyn_next = dyn_next & ~east_clr;
    if (north_on) dyn_next = dyn_next & ~north_clr;
    if (south_on) dyn_next = dyn_next & ~south_clr;
    eff_next = s1_raw & static_mask & dyn_next;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      effective_detect <= eff_next;
      dynamic_mask <= dyn_next;
      detection_valid <= |eff_next;
    end
  end

endmodule

### rtl/wfsm_checker.sv
// Port-level checks for the wall-facing sensor mask unit, bound to the top level.
// Depends on wfsm_pkg.
module wfsm_checker (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input wfsm_pkg::mask_t effective_detect,
  input wfsm_pkg::mask_t dynamic_mask,
  input logic            detection_valid
);
  import wfsm_pkg::*;

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(effective_detect)
      && $stable(dynamic_mask) && $stable(detection_valid))
    else $error("output word changed while stalled");

  // The flag tracks the detection bits.
  a_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> detection_valid == (effective_detect != '0))
    else $error("detection flag does not match detection bits");

  // No detection survives on a masked sensor.
  a_masked: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (effective_detect & ~dynamic_mask) == '0)
    else $error("detection on a sensor cleared by wall masking");

  // Nothing is shown right after reset.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind wall_facing_sensor_mask_unit wfsm_checker u_wfsm_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .effective_detect(effective_detect),
  .dynamic_mask(dynamic_mask),
  .detection_valid(detection_valid)
);
